// ===== hdl/rad_pkg.sv =====
// ----------------------------------------------------------------------------
// rad_pkg: shared constants and types for the range average decimate gate
// Window geometry, derived widths, register indexes and reset values, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rad_pkg;

  localparam int WINDOW_LEN  = 5;
  localparam int SAMPLE_BITS = 16;

  localparam int AVG_BITS = 16;

  // sum of a full window of samples
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);
  // fill count holds 0 .. WINDOW_LEN
  localparam int CNT_BITS = $clog2(WINDOW_LEN + 1);
  localparam int POS_BITS = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // divider retires DIV_RADIX_BITS quotient bits per cycle
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = (SUM_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_W          = DIV_STEPS * DIV_RADIX_BITS;
  localparam int STEP_BITS      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // compare width for the unsaturated average
  localparam int CMP_W = (DIV_W > AVG_BITS) ? DIV_W : AVG_BITS;

  localparam int DEC_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VALID  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VALID  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DECIMATION = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT = 2'd3;

  localparam logic [15:0]         RST_MIN_VALID  = 16'd5;
  localparam logic [15:0]         RST_MAX_VALID  = 16'd4000;
  localparam logic [DEC_BITS-1:0] RST_DECIMATION = 8'd4;
  localparam logic [15:0]         RST_NEAR_LIMIT = 16'd200;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } rad_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } rad_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rad_stream_if.sv =====
// ----------------------------------------------------------------------------
// rad_stream_if: valid/ready channels of the range average decimate gate
// Sample channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface rad_in_if import rad_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] distance_sample;

  modport source (output valid, output distance_sample, input ready);
  modport sink   (input valid, input distance_sample, output ready);
endinterface

interface rad_out_if import rad_pkg::*;;
  logic                valid;
  logic                ready;
  logic [AVG_BITS-1:0] avg_distance;
  logic                in_range;
  logic                near_flag;

  modport source (output valid, output avg_distance, output in_range, output near_flag,
                  input ready);
  modport sink   (input valid, input avg_distance, input in_range, input near_flag,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/rad_ctrl.sv =====
// ----------------------------------------------------------------------------
// rad_ctrl: sequencer for the range average decimate gate
// Takes a word, runs the divider steps, then hands the result to the output
// register when a result is due and the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rad_ctrl import rad_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rad_stat_t stat,
  output rad_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

  logic [1:0]           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_nxt   = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.emit) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rad_datapath.sv =====
// ----------------------------------------------------------------------------
// rad_datapath: window, running sum, divider and output register
// Keeps the sample window with a running sum, divides the sum by the fill
// count DIV_RADIX_BITS quotient bits per cycle, and forms the gated result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rad_datapath import rad_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic [SAMPLE_BITS-1:0]   sample,
  input  wire rad_cmd_t                 cmd,
  output rad_stat_t                     stat,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [AVG_BITS-1:0]           avg_distance,
  output logic                          in_range,
  output logic                          near_flag
);

  localparam logic [AVG_BITS-1:0] AVG_MAX = '1;

  // configuration registers
  logic [15:0]         min_r, min_nxt;
  logic [15:0]         max_r, max_nxt;
  logic [DEC_BITS-1:0] dec_r, dec_nxt;
  logic [15:0]         near_r, near_nxt;

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    dec_nxt  = dec_r;
    near_nxt = near_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_VALID:  min_nxt  = cfg_wdata[15:0];
        CFG_MAX_VALID:  max_nxt  = cfg_wdata[15:0];
        CFG_DECIMATION: dec_nxt  = cfg_wdata[DEC_BITS-1:0];
        CFG_NEAR_LIMIT: near_nxt = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= RST_MIN_VALID;
      max_r  <= RST_MAX_VALID;
      dec_r  <= RST_DECIMATION;
      near_r <= RST_NEAR_LIMIT;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      dec_r  <= dec_nxt;
      near_r <= near_nxt;
    end
  end

  // window and running sum
  logic [SAMPLE_BITS-1:0] win_r [WINDOW_LEN];
  logic [POS_BITS-1:0]    wpos_r, wpos_nxt;
  logic [CNT_BITS-1:0]    fill_r, fill_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [DEC_BITS-1:0]    decim_r, decim_nxt, decim_inc;
  logic                   emit_r, emit_nxt;
  logic                   full;
  logic [SAMPLE_BITS-1:0] old_sample;

  assign full       = (fill_r == CNT_BITS'(WINDOW_LEN));
  assign old_sample = win_r[wpos_r];
  assign decim_inc  = decim_r + 1'b1;

  always_comb begin
    wpos_nxt  = wpos_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    decim_nxt = decim_r;
    emit_nxt  = emit_r;
    if (cmd.accept) begin
      wpos_nxt = (wpos_r == POS_BITS'(WINDOW_LEN - 1)) ? '0 : wpos_r + 1'b1;
      fill_nxt = full ? fill_r : fill_r + 1'b1;
      sum_nxt  = sum_r + SUM_BITS'(sample) - (full ? SUM_BITS'(old_sample) : '0);
      emit_nxt = !(decim_inc < dec_r);
      decim_nxt = emit_nxt ? '0 : decim_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_r[wpos_r] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      decim_r <= '0;
      emit_r  <= 1'b0;
    end else begin
      wpos_r  <= wpos_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      decim_r <= decim_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // restoring divider by the fill count, DIV_RADIX_BITS bits per step
  logic [DIV_W-1:0]    quo_r, quo_nxt, quo_v;
  logic [CNT_BITS-1:0] rem_r, rem_nxt, rem_v;
  logic [CNT_BITS:0]   trial;

  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial = {rem_v, quo_v[DIV_W-1]};
      quo_v = {quo_v[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, fill_r}) begin
        trial    = trial - {1'b0, fill_r};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[CNT_BITS-1:0];
    end
  end

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (cmd.accept) begin
      quo_nxt = DIV_W'(sum_nxt);
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      quo_nxt = quo_v;
      rem_nxt = rem_v;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  // result word
  logic [CMP_W-1:0]    q_ext;
  logic [AVG_BITS-1:0] avg_r, avg_nxt;
  logic                rng_r, rng_nxt;
  logic                near_f_r, near_f_nxt;
  logic                ovalid_r, ovalid_nxt;

  assign q_ext = CMP_W'(quo_r);

  always_comb begin
    avg_nxt    = avg_r;
    rng_nxt    = rng_r;
    near_f_nxt = near_f_r;
    ovalid_nxt = ovalid_r && !out_ready;
    if (cmd.load_out) begin
      avg_nxt    = (q_ext > CMP_W'(AVG_MAX)) ? AVG_MAX : q_ext[AVG_BITS-1:0];
      rng_nxt    = (q_ext >= CMP_W'(min_r)) && (q_ext <= CMP_W'(max_r));
      near_f_nxt = (q_ext < CMP_W'(near_r));
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    avg_r    <= avg_nxt;
    rng_r    <= rng_nxt;
    near_f_r <= near_f_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  assign stat.emit     = emit_r;
  assign stat.out_free = !ovalid_r || out_ready;

  assign out_valid    = ovalid_r;
  assign avg_distance = avg_r;
  assign in_range     = rng_r;
  assign near_flag    = near_f_r;

endmodule

`default_nettype wire

// ===== hdl/range_average_decimate_gate_core.sv =====
// ----------------------------------------------------------------------------
// range_average_decimate_gate_core: windowed range average with decimation
// Averages the last five range samples (fewer while the window fills) and emits a
// gated result word on every Nth sample with valid-band and near flags.
// ----------------------------------------------------------------------------
// after the sample word is taken, the divider steps run and then the result loads
// samples are taken one at a time: accept, 5 divider steps of 4 bits, output
// the output register lets the next sample in while a result waits; a second
// due result holds the input until the first word is taken
// reset (synchronous, rst_n low): window empty, counters zero, registers to
// their defaults, no result pending
`default_nettype none

module range_average_decimate_gate_core import rad_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  rad_in_if.sink                        in_chan,
  rad_out_if.source                     out_chan,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  rad_cmd_t  cmd;
  rad_stat_t stat;

  rad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rad_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .sample       (in_chan.distance_sample),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .avg_distance (out_chan.avg_distance),
    .in_range     (out_chan.in_range),
    .near_flag    (out_chan.near_flag)
  );

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("sample word taken while another is in flight");

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.div_step, cmd.load_out}))
    else $error("controller issued overlapping commands");

  // result load never overwrites an untaken word
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_chan.valid || out_chan.ready))
    else $error("result word overwritten before it was taken");

  // loaded result shows up next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_chan.valid)
    else $error("loaded result word not presented");

endmodule

`default_nettype wire
